// ----- src/frx_pkg.sv -----
// Shared types for the frame receiver: byte roles and the per-beat result record.
// No dependencies; imported by every module of the block.
package frx_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SumW   = 16;
  localparam int unsigned TdataW = 4 * ByteW;
  localparam int unsigned TuserW = 4;

  typedef enum logic [1:0] {
    ROLE_CODE    = 2'd0,
    ROLE_SIZE    = 2'd1,
    ROLE_PAYLOAD = 2'd2,
    ROLE_CHECK   = 2'd3
  } role_t;

  typedef struct packed {
    role_t              byte_role;
    logic [ByteW-1:0]   data_out;
    logic [ByteW-1:0]   payload_index;
    logic               frame_start;
    logic               frame_end;
    logic               frame_valid;
    logic [ByteW-1:0]   frame_code;
    logic [ByteW-1:0]   frame_length;
  } result_t;

endpackage

// ----- src/frx_in_stage.sv -----
// Input register of the frame receiver: holds one received byte beat.
// Depends on frx_pkg.
module frx_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [frx_pkg::ByteW-1:0] in_byte,
  output logic                      hold_valid,
  output logic [frx_pkg::ByteW-1:0] hold_byte,
  input  logic                      take
);
  import frx_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [ByteW-1:0] byte_r;

  // Room when empty or when the held beat moves on this cycle.
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

// ----- src/frx_core.sv -----
// Frame tracking state and per-byte decode: role, payload index, running sum, verdict.
// Depends on frx_pkg.
module frx_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [frx_pkg::ByteW-1:0] rx_byte,
  output frx_pkg::result_t          result
);
  import frx_pkg::*;

  role_t            phase_r, phase_nxt;
  logic [SumW-1:0]  sum_r, sum_nxt;
  logic [ByteW-1:0] code_r, code_nxt;
  logic [ByteW-1:0] len_r, len_nxt;
  logic [ByteW-1:0] cnt_r, cnt_nxt;
  logic [ByteW-1:0] cnt_inc;
  logic [ByteW-1:0] folded;

  assign cnt_inc = cnt_r + 1'b1;
  // Fold of the 16-bit sum to one byte: low byte plus high byte, carry of that add dropped.
  assign folded  = sum_r[ByteW-1:0] + sum_r[SumW-1:ByteW];

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    code_nxt  = code_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    result    = '0;
    result.byte_role = phase_r;
    result.data_out  = rx_byte;
    unique case (phase_r)
      ROLE_CODE: begin
        result.frame_start = 1'b1;
        code_nxt  = rx_byte;
        len_nxt   = '0;
        cnt_nxt   = '0;
        sum_nxt   = {{(SumW-ByteW){1'b0}}, rx_byte};
        phase_nxt = ROLE_SIZE;
      end
      ROLE_SIZE: begin
        len_nxt   = rx_byte;
        cnt_nxt   = '0;
        sum_nxt   = sum_r + {{(SumW-ByteW){1'b0}}, rx_byte};
        phase_nxt = (rx_byte != '0) ? ROLE_PAYLOAD : ROLE_CHECK;
      end
      ROLE_PAYLOAD: begin
        result.payload_index = cnt_r;
        sum_nxt = sum_r + {{(SumW-ByteW){1'b0}}, rx_byte};
        cnt_nxt = cnt_inc;
        if (cnt_inc == len_r) begin
          phase_nxt = ROLE_CHECK;
        end
      end
      ROLE_CHECK: begin
        result.frame_end   = 1'b1;
        // Zero checksum byte means "not checked".
        result.frame_valid = (rx_byte == '0) || (folded == rx_byte);
        phase_nxt          = ROLE_CODE;
      end
    endcase
    result.frame_code   = code_nxt;
    result.frame_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ROLE_CODE;
      sum_r   <= '0;
      code_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      code_r  <= code_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- src/frx_out_stage.sv -----
// Result register of the frame receiver: holds one result beat until taken.
// Depends on frx_pkg.
module frx_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_valid,
  output logic             load_ready,
  input  frx_pkg::result_t load_data,
  output logic             out_valid,
  input  logic             out_ready,
  output frx_pkg::result_t out_data
);
  import frx_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  assign load_ready = !valid_r || out_ready;
  assign valid_nxt  = (load_valid && load_ready) || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load_valid && load_ready) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- src/frame_receiver_with_checksum.sv -----
// Frame receiver with folded-sum checksum, top level.
// Depends on frx_pkg, frx_in_stage, frx_core and frx_out_stage.
//
// Usage:
//   Received bytes enter on the in_ stream, one byte per beat. The stream is
//   cut into frames of code byte, size byte, size payload bytes and one
//   checksum byte. Every input beat yields exactly one result beat on the
//   out_ stream that tags the byte with its role and frame information.
//   out_tlast marks the checksum byte; out_tuser[3] then gives the verdict
//   (checksum matched the folded sum, or checksum was zero).
//   Path: a byte accepted on in_ is registered in the input register, decoded
//   while held there and loaded into the result register once that has
//   room, which raises out_tvalid. Throughput: one byte per cycle while
//   out_tready is high, as the sum, count and compare logic between the
//   input and result registers is combinational.
//   Stall: while out_tready is low the result register holds its beat; the
//   input register still takes one more byte, then in_tready drops.
//   Reset (rst_n low, synchronous): both stages empty, the receiver waits
//   for a code byte with a cleared sum, code and length.
//   After each checksum byte the receiver re-arms itself for the next code.
module frame_receiver_with_checksum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [frx_pkg::ByteW-1:0]  in_tdata,   // [7:0] rx_byte
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [frx_pkg::TdataW-1:0] out_tdata,  // [7:0] data_out, [15:8] payload_index,
                                                 // [23:16] frame_code, [31:24] frame_length
  output logic [frx_pkg::TuserW-1:0] out_tuser,  // [1:0] byte_role, [2] frame_start,
                                                 // [3] frame_valid
  output logic                       out_tlast   // frame_end
);
  import frx_pkg::*;

  logic             hold_valid;
  logic [ByteW-1:0] hold_byte;
  logic             load_ready;
  logic             step;
  result_t          core_result;
  result_t          out_result;

  // A held byte is decoded in the cycle it moves into the result register.
  assign step = hold_valid && load_ready;

  frx_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .take       (step)
  );

  frx_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (hold_byte),
    .result  (core_result)
  );

  frx_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (hold_valid),
    .load_ready (load_ready),
    .load_data  (core_result),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_result)
  );

  assign out_tdata = {out_result.frame_length, out_result.frame_code,
                      out_result.payload_index, out_result.data_out};
  assign out_tuser = {out_result.frame_valid, out_result.frame_start, out_result.byte_role};
  assign out_tlast = out_result.frame_end;

endmodule
